### hw/rtl/bcpe_pkg.sv
// Shared types and constants of the Bezier curve point evaluator.
package bcpe_pkg;

    // Q1.16 one
    localparam logic [16:0] ONE_Q16 = 17'h10000;

    // Shared multiplier: signed A by signed B
    localparam int MA_W = 34;
    localparam int MB_W = 18;
    localparam int MP_W = MA_W + MB_W;

    // Weight product u^k * v^(n-k), and that times the binomial
    localparam int W_W  = 33;
    localparam int CW_W = 42;
    // Partial term and running sum widths
    localparam int T_W   = 50;
    localparam int SUM_W = 48;

    // Configuration port
    localparam int PADDR_W = 3;
    localparam logic REG_NUM_POINTS = 1'b0;

    // Opcodes
    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_EVAL = 1'b1;

    // Binomial coefficients C(n,k) for n up to 12 (supports up to 13 points)
    localparam int BINOM_N = 13;
    localparam int BINOM_IDX_W = 4;
    localparam logic [9:0] BINOM_TAB [0:BINOM_N-1][0:BINOM_N-1] = '{
        '{10'd1, 10'd0,  10'd0,  10'd0,   10'd0,   10'd0,   10'd0,
          10'd0, 10'd0,  10'd0,  10'd0,   10'd0,   10'd0},
        '{10'd1, 10'd1,  10'd0,  10'd0,   10'd0,   10'd0,   10'd0,
          10'd0, 10'd0,  10'd0,  10'd0,   10'd0,   10'd0},
        '{10'd1, 10'd2,  10'd1,  10'd0,   10'd0,   10'd0,   10'd0,
          10'd0, 10'd0,  10'd0,  10'd0,   10'd0,   10'd0},
        '{10'd1, 10'd3,  10'd3,  10'd1,   10'd0,   10'd0,   10'd0,
          10'd0, 10'd0,  10'd0,  10'd0,   10'd0,   10'd0},
        '{10'd1, 10'd4,  10'd6,  10'd4,   10'd1,   10'd0,   10'd0,
          10'd0, 10'd0,  10'd0,  10'd0,   10'd0,   10'd0},
        '{10'd1, 10'd5,  10'd10, 10'd10,  10'd5,   10'd1,   10'd0,
          10'd0, 10'd0,  10'd0,  10'd0,   10'd0,   10'd0},
        '{10'd1, 10'd6,  10'd15, 10'd20,  10'd15,  10'd6,   10'd1,
          10'd0, 10'd0,  10'd0,  10'd0,   10'd0,   10'd0},
        '{10'd1, 10'd7,  10'd21, 10'd35,  10'd35,  10'd21,  10'd7,
          10'd1, 10'd0,  10'd0,  10'd0,   10'd0,   10'd0},
        '{10'd1, 10'd8,  10'd28, 10'd56,  10'd70,  10'd56,  10'd28,
          10'd8, 10'd1,  10'd0,  10'd0,   10'd0,   10'd0},
        '{10'd1, 10'd9,  10'd36, 10'd84,  10'd126, 10'd126, 10'd84,
          10'd36, 10'd9, 10'd1,  10'd0,   10'd0,   10'd0},
        '{10'd1, 10'd10, 10'd45, 10'd120, 10'd210, 10'd252, 10'd210,
          10'd120, 10'd45, 10'd10, 10'd1, 10'd0,   10'd0},
        '{10'd1, 10'd11, 10'd55, 10'd165, 10'd330, 10'd462, 10'd462,
          10'd330, 10'd165, 10'd55, 10'd11, 10'd1, 10'd0},
        '{10'd1, 10'd12, 10'd66, 10'd220, 10'd495, 10'd792, 10'd924,
          10'd792, 10'd495, 10'd220, 10'd66, 10'd12, 10'd1}
    };

    typedef struct packed {
        logic               opcode;
        logic [2:0]         point_index;
        logic signed [31:0] point_x;
        logic signed [31:0] point_y;
        logic signed [31:0] point_z;
        logic [16:0]        param_u;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0] curve_x;
        logic signed [31:0] curve_y;
        logic signed [31:0] curve_z;
    } t_out_item;

endpackage

### hw/rtl/bcpe_in_if.sv
// Input channel of the Bezier curve point evaluator.
interface bcpe_in_if;
    logic               valid;
    logic               ready;
    bcpe_pkg::t_in_item data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

### hw/rtl/bcpe_out_if.sv
// Result channel of the Bezier curve point evaluator.
interface bcpe_out_if;
    logic                valid;
    logic                ready;
    bcpe_pkg::t_out_item data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

### hw/rtl/bezier_curve_point_eval.sv
// Bezier curve point evaluator: holds control points, evaluates the Bernstein sum.
// A load transaction writes one control point and gives no result.
// An evaluate transaction with c points in use (c = min(num_points, MAX_POINTS)) keeps
// i_in.ready low through all of its steps, the final one waiting until the previous
// result is taken. With c zero only that final step runs; else c-1 steps build the powers of u, each
// point takes 12 steps on the one shared 34x18 signed multiplier (weight, binomial
// scaling, three slices of the scaled weight per coordinate, next power of 1-u), and one
// step saturates the sums into the output register. The result waits in that register, so
// loads and a new evaluate are taken while it is still pending. The point store is
// cleared by reset.
module bezier_curve_point_eval #(
    parameter int MAX_POINTS = 8
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    bcpe_in_if.sink                       i_in,
    bcpe_out_if.source                    o_out,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [bcpe_pkg::PADDR_W-1:0]  paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);

    localparam int IDX_W = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;

    typedef enum logic [3:0] {
        S_IDLE, S_POW, S_W, S_CW, S_M0, S_M1, S_M2, S_PV, S_SAT
    } t_state;

    typedef enum logic [1:0] {
        CRD_X, CRD_Y, CRD_Z
    } t_crd;

    t_state r_state;
    t_crd   r_crd;
    t_crd   r_term_crd;

    logic [3:0]                          r_num_points;
    logic signed [31:0]                  r_sx [MAX_POINTS];
    logic signed [31:0]                  r_sy [MAX_POINTS];
    logic signed [31:0]                  r_sz [MAX_POINTS];
    logic [16:0]                         r_pu [MAX_POINTS];
    logic [16:0]                         r_u;
    logic [16:0]                         r_v;
    logic [16:0]                         r_pw;
    logic [16:0]                         r_pv;
    logic [3:0]                          r_n;
    logic [IDX_W-1:0]                    r_k;
    logic [bcpe_pkg::W_W-1:0]            r_w;
    logic [bcpe_pkg::CW_W-1:0]           r_cw;
    logic signed [bcpe_pkg::T_W-1:0]     r_t;
    logic signed [bcpe_pkg::T_W-1:0]     r_term;
    logic                                r_term_vld;
    logic signed [bcpe_pkg::SUM_W-1:0]   r_sum [3];
    logic                                r_out_valid;
    bcpe_pkg::t_out_item                 r_out;

    logic signed [bcpe_pkg::MA_W-1:0]    mul_a;
    logic signed [bcpe_pkg::MB_W-1:0]    mul_b;
    logic signed [bcpe_pkg::MP_W-1:0]    prod;
    logic signed [bcpe_pkg::T_W-1:0]     prod_t;
    logic signed [bcpe_pkg::T_W-1:0]     t_next;
    logic signed [31:0]                  pt;
    logic [9:0]                          binom;
    logic [3:0]                          cnt;
    logic [16:0]                         u_clamp;
    logic                                in_acc;
    logic                                out_free;

    function automatic logic signed [31:0] sat32(input logic signed [bcpe_pkg::SUM_W-1:0] s);
        logic signed [31:0] r;
        if ((&s[bcpe_pkg::SUM_W-1:31]) || !(|s[bcpe_pkg::SUM_W-1:31])) begin
            r = s[31:0];
        end else if (s[bcpe_pkg::SUM_W-1]) begin
            r = 32'sh8000_0000;
        end else begin
            r = 32'sh7FFF_FFFF;
        end
        return r;
    endfunction

    assign pready      = 1'b1;
    assign prdata      = (paddr[2] == bcpe_pkg::REG_NUM_POINTS) ? {28'd0, r_num_points} : 32'd0;
    assign i_in.ready  = (r_state == S_IDLE);
    assign in_acc      = i_in.valid && (r_state == S_IDLE);
    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out;
    assign out_free    = !r_out_valid || o_out.ready;

    assign cnt     = (r_num_points > 4'(MAX_POINTS)) ? 4'(MAX_POINTS) : r_num_points;
    assign u_clamp = (i_in.data.param_u > bcpe_pkg::ONE_Q16) ? bcpe_pkg::ONE_Q16
                                                             : i_in.data.param_u;
    assign binom   = bcpe_pkg::BINOM_TAB[r_n][4'(r_k)];

    // Select the stored coordinate for the current slice
    always_comb begin
        case (r_crd)
            CRD_X:   pt = r_sx[r_k];
            CRD_Y:   pt = r_sy[r_k];
            CRD_Z:   pt = r_sz[r_k];
            default: pt = r_sx[r_k];
        endcase
    end

    // Operand routing into the shared multiplier
    always_comb begin
        case (r_state)
            S_POW: begin
                mul_a = $signed({17'd0, r_pw});
                mul_b = $signed({1'b0, r_u});
            end
            S_W: begin
                mul_a = $signed({17'd0, r_pv});
                mul_b = $signed({1'b0, r_pu[r_k]});
            end
            S_CW: begin
                mul_a = $signed({1'b0, r_w});
                mul_b = $signed({8'd0, binom});
            end
            S_M0: begin
                mul_a = $signed({{2{pt[31]}}, pt});
                mul_b = $signed({2'd0, r_cw[15:0]});
            end
            S_M1: begin
                mul_a = $signed({{2{pt[31]}}, pt});
                mul_b = $signed({2'd0, r_cw[31:16]});
            end
            S_M2: begin
                mul_a = $signed({{2{pt[31]}}, pt});
                mul_b = $signed({8'd0, r_cw[41:32]});
            end
            S_PV: begin
                mul_a = $signed({17'd0, r_pv});
                mul_b = $signed({1'b0, r_v});
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign prod   = mul_a * mul_b;
    assign prod_t = $signed(prod[bcpe_pkg::T_W-1:0]);
    // Floor of the partial so far, then add the next slice one digit up
    assign t_next = (r_t >>> 16) + prod_t;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_num_points <= '0;
            r_out_valid  <= 1'b0;
            r_term_vld   <= 1'b0;
            for (int i = 0; i < MAX_POINTS; i++) begin
                r_sx[i] <= '0;
                r_sy[i] <= '0;
                r_sz[i] <= '0;
            end
        end else begin
            if (psel && penable && pwrite && (paddr[2] == bcpe_pkg::REG_NUM_POINTS)) begin
                r_num_points <= pwdata[3:0];
            end

            if (r_out_valid && o_out.ready) begin
                r_out_valid <= 1'b0;
            end

            // Retire the finished term in the cycle after the multiplier produced it
            r_term_vld <= 1'b0;
            if (r_term_vld) begin
                r_sum[r_term_crd] <= r_sum[r_term_crd]
                                     + $signed(r_term[bcpe_pkg::SUM_W-1:0]);
            end

            case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        if (i_in.data.opcode == bcpe_pkg::OP_LOAD) begin
                            if (32'(i_in.data.point_index) < MAX_POINTS) begin
                                r_sx[IDX_W'(i_in.data.point_index)] <= i_in.data.point_x;
                                r_sy[IDX_W'(i_in.data.point_index)] <= i_in.data.point_y;
                                r_sz[IDX_W'(i_in.data.point_index)] <= i_in.data.point_z;
                            end
                        end else begin
                            r_u      <= u_clamp;
                            r_v      <= bcpe_pkg::ONE_Q16 - u_clamp;
                            r_sum[0] <= '0;
                            r_sum[1] <= '0;
                            r_sum[2] <= '0;
                            r_pu[0]  <= bcpe_pkg::ONE_Q16;
                            r_pw     <= bcpe_pkg::ONE_Q16;
                            r_pv     <= bcpe_pkg::ONE_Q16;
                            r_n      <= cnt - 4'd1;
                            if (cnt == 4'd0) begin
                                r_state <= S_SAT;
                            end else if (cnt == 4'd1) begin
                                r_k     <= '0;
                                r_state <= S_W;
                            end else begin
                                r_k     <= IDX_W'(1);
                                r_state <= S_POW;
                            end
                        end
                    end
                end
                S_POW: begin
                    r_pu[r_k] <= prod[32:16];
                    r_pw      <= prod[32:16];
                    if (4'(r_k) == r_n) begin
                        r_state <= S_W;
                    end else begin
                        r_k <= r_k + IDX_W'(1);
                    end
                end
                S_W: begin
                    r_w     <= prod[bcpe_pkg::W_W-1:0];
                    r_state <= S_CW;
                end
                S_CW: begin
                    r_cw    <= prod[bcpe_pkg::CW_W-1:0];
                    r_crd   <= CRD_X;
                    r_state <= S_M0;
                end
                S_M0: begin
                    r_t     <= prod_t;
                    r_state <= S_M1;
                end
                S_M1: begin
                    r_t     <= t_next;
                    r_state <= S_M2;
                end
                S_M2: begin
                    r_term     <= t_next;
                    r_term_vld <= 1'b1;
                    r_term_crd <= r_crd;
                    if (r_crd == CRD_Z) begin
                        r_state <= S_PV;
                    end else begin
                        r_crd   <= t_crd'(r_crd + 2'd1);
                        r_state <= S_M0;
                    end
                end
                S_PV: begin
                    r_pv <= prod[32:16];
                    if (r_k == '0) begin
                        r_state <= S_SAT;
                    end else begin
                        r_k     <= r_k - IDX_W'(1);
                        r_state <= S_W;
                    end
                end
                S_SAT: begin
                    if (out_free) begin
                        r_out.curve_x <= sat32(r_sum[0]);
                        r_out.curve_y <= sat32(r_sum[1]);
                        r_out.curve_z <= sat32(r_sum[2]);
                        r_out_valid   <= 1'b1;
                        r_state       <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

`ifndef ASSERT_OFF
    // No term may still be in flight once the sequencer is back to taking input
    a_no_term_in_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !r_term_vld)
        else $error("term still pending while idle");

    // A pending result blocks the final step until it is taken
    a_sat_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SAT) && r_out_valid && !o_out.ready |=> (r_state == S_SAT))
        else $error("result overwritten while pending");

    // A new result only appears out of the final step
    a_result_from_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> ($past(r_state) == S_SAT))
        else $error("result raised outside the final step");

    // The running power of 1-u never exceeds one
    a_pv_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_W) |-> (r_pv <= bcpe_pkg::ONE_Q16))
        else $error("power of 1-u out of range");
`endif

endmodule

### tb/sv/bezier_curve_point_eval_tb.sv
// Self-checking testbench of the Bezier curve point evaluator with its own curve predictor.
`timescale 1ns / 1ps

module bezier_curve_point_eval_tb;

    localparam int MAX_PTS = 8;
    localparam int IDLE_LIMIT = 4000;
    localparam int SETTLE_CYCLES = 150;
    localparam int PHASES = 12;
    localparam int PHASE_ITEMS = 150;
    localparam logic [bcpe_pkg::PADDR_W-1:0] NUM_POINTS_ADDR =
        {bcpe_pkg::REG_NUM_POINTS, 2'b00};
    localparam logic [31:0] Q_MAX = 32'h7FFF_FFFF;
    localparam logic [31:0] Q_MIN = 32'h8000_0000;

    logic                         i_clk = 1'b0;
    logic                         i_rst_n;
    logic                         psel;
    logic                         penable;
    logic                         pwrite;
    logic [bcpe_pkg::PADDR_W-1:0] paddr;
    logic [31:0]                  pwdata;
    logic [31:0]                  prdata;
    logic                         pready;

    bcpe_in_if  in_ch();
    bcpe_out_if out_ch();

    bezier_curve_point_eval #(
        .MAX_POINTS(MAX_PTS)
    ) uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // Predictor state: control points per axis and the point count register
    logic signed [31:0] ctl_pt [0:2][0:MAX_PTS-1] = '{default: '0};
    logic [3:0]         pts_cfg = '0;

    bcpe_pkg::t_in_item  stim_q[$];
    bcpe_pkg::t_out_item curve_due[$];
    string               field_tag [0:2] = '{"curve_x", "curve_y", "curve_z"};

    int queued_cnt = 0;
    int taken_cnt = 0;
    int mismatches = 0;
    int src_odds = 0;
    int snk_odds = 0;
    int gap_left = 0;
    int stall_left = 0;
    int quiet_cycles = 0;

    always #5 i_clk = ~i_clk;

    // Bernstein sum at u over the points in use, each term floored, sum saturated
    function automatic bcpe_pkg::t_out_item bernstein_point(logic [16:0] u_in);
        logic [63:0]         pw_u [0:MAX_PTS-1];
        logic [63:0]         pw_v [0:MAX_PTS-1];
        logic signed [127:0] acc;
        logic signed [127:0] pt;
        logic [63:0]         u;
        logic [63:0]         v;
        logic [63:0]         binom;
        logic [63:0]         wgt;
        logic [95:0]         res;
        int                  cnt;
        int                  deg;
        u = (u_in > bcpe_pkg::ONE_Q16) ? 64'(bcpe_pkg::ONE_Q16) : 64'(u_in);
        v = 64'(bcpe_pkg::ONE_Q16) - u;
        cnt = (pts_cfg > MAX_PTS) ? MAX_PTS : int'(pts_cfg);
        deg = cnt - 1;
        pw_u[0] = 64'(bcpe_pkg::ONE_Q16);
        pw_v[0] = 64'(bcpe_pkg::ONE_Q16);
        for (int k = 1; k < cnt; k++) begin
            pw_u[k] = (pw_u[k - 1] * u) >> 16;
            pw_v[k] = (pw_v[k - 1] * v) >> 16;
        end
        for (int a = 0; a < 3; a++) begin
            acc = '0;
            binom = 64'd1;
            for (int k = 0; k < cnt; k++) begin
                wgt = binom * pw_u[k] * pw_v[deg - k];
                pt = ctl_pt[a][k];
                acc += (pt * $signed({64'd0, wgt})) >>> 32;
                binom = binom * 64'(deg - k) / 64'(k + 1);
            end
            if (acc > 128'sd2147483647)
                res[95 - 32 * a -: 32] = Q_MAX;
            else if (acc < -128'sd2147483648)
                res[95 - 32 * a -: 32] = Q_MIN;
            else
                res[95 - 32 * a -: 32] = acc[31:0];
        end
        return bcpe_pkg::t_out_item'(res);
    endfunction

    function automatic void queue_item(logic op, logic [2:0] slot, logic [31:0] x,
                                       logic [31:0] y, logic [31:0] z, logic [16:0] u);
        bcpe_pkg::t_in_item it;
        it.opcode = op;
        it.point_index = slot;
        it.point_x = x;
        it.point_y = y;
        it.point_z = z;
        it.param_u = u;
        stim_q.push_back(it);
        queued_cnt++;
    endfunction

    function automatic logic [31:0] pick_coord();
        case ($urandom_range(0, 7))
            0: return Q_MAX;
            1: return Q_MIN;
            2: return 32'(int'($urandom_range(0, 131072)) - 65536);
            default: return $urandom();
        endcase
    endfunction

    function automatic logic [16:0] pick_u();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return bcpe_pkg::ONE_Q16;
            2: return 17'($urandom_range(65537, 131071));
            default: return 17'($urandom_range(0, 65536));
        endcase
    endfunction

    task automatic write_point_count(logic [3:0] val);
        @(posedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= NUM_POINTS_ADDR;
        pwdata <= 32'(val);
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        pts_cfg = val;
    endtask

    // Hold until every item is taken and every result checked, then let the block settle
    task automatic drain();
        while (taken_cnt != queued_cnt || curve_due.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Input driver: predict on each accepted transaction, then present the next item
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (in_ch.valid && in_ch.ready) begin
                taken_cnt++;
                if (in_ch.data.opcode == bcpe_pkg::OP_LOAD) begin
                    ctl_pt[0][in_ch.data.point_index] = in_ch.data.point_x;
                    ctl_pt[1][in_ch.data.point_index] = in_ch.data.point_y;
                    ctl_pt[2][in_ch.data.point_index] = in_ch.data.point_z;
                end else begin
                    curve_due.push_back(bernstein_point(in_ch.data.param_u));
                end
            end
            if (!in_ch.valid || in_ch.ready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    in_ch.valid <= 1'b0;
                end else if (stim_q.size() != 0 && src_odds != 0
                             && $urandom_range(0, src_odds - 1) == 0) begin
                    gap_left = $urandom_range(0, 11);
                    in_ch.valid <= 1'b0;
                end else if (stim_q.size() != 0) begin
                    in_ch.data <= stim_q.pop_front();
                    in_ch.valid <= 1'b1;
                end else begin
                    in_ch.valid <= 1'b0;
                end
            end
        end
    end

    // Result monitor: compare against the oldest prediction, stall in bursts
    always @(posedge i_clk) begin
        bcpe_pkg::t_out_item want;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (curve_due.size() == 0) begin
                $error("curve result with no evaluate pending");
                mismatches++;
            end else begin
                want = curve_due.pop_front();
                for (int a = 0; a < 3; a++) begin
                    if (out_ch.data[95 - 32 * a -: 32] !== want[95 - 32 * a -: 32]) begin
                        $error("%s: expected %0d, got %0d", field_tag[a],
                               $signed(want[95 - 32 * a -: 32]),
                               $signed(out_ch.data[95 - 32 * a -: 32]));
                        mismatches++;
                    end
                end
            end
        end
        if (stall_left > 0) begin
            stall_left--;
            out_ch.ready <= 1'b0;
        end else if (snk_odds != 0 && $urandom_range(0, snk_odds - 1) == 0) begin
            stall_left = $urandom_range(0, 11);
            out_ch.ready <= 1'b0;
        end else begin
            out_ch.ready <= 1'b1;
        end
    end

    // Watchdog: end the run when no transaction moves for too long
    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || (psel && penable))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= IDLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    initial begin
        logic [16:0] corner_u [0:5];
        logic [3:0]  cfg;
        corner_u = '{17'd0, bcpe_pkg::ONE_Q16, 17'd32768, 17'h1FFFF, 17'd1, 17'd65535};
        in_ch.valid = 1'b0;
        in_ch.data = '0;
        out_ch.ready = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        i_rst_n = 1'b0;
        src_odds = 4;
        snk_odds = 4;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // No points in use after reset: all-zero result
        queue_item(bcpe_pkg::OP_EVAL, 3'd5, Q_MAX, Q_MIN, Q_MAX, bcpe_pkg::ONE_Q16);
        drain();

        write_point_count(4'(MAX_PTS));
        for (int k = 0; k < MAX_PTS; k++)
            queue_item(bcpe_pkg::OP_LOAD, 3'(k), Q_MAX, Q_MIN,
                       k[0] ? 32'hAAAA_AAAA : 32'h5555_5555, 17'h1FFFF);
        foreach (corner_u[i])
            queue_item(bcpe_pkg::OP_EVAL, 3'(i), Q_MIN, Q_MAX, 32'hFFFF_FFFF, corner_u[i]);
        drain();

        // Count above the store depth: clamp to all points
        write_point_count(4'hF);
        queue_item(bcpe_pkg::OP_EVAL, 3'd7, '0, '0, '0, 17'd12345);
        queue_item(bcpe_pkg::OP_EVAL, 3'd0, '0, '0, '0, 17'h10001);
        drain();

        write_point_count(4'd1);
        queue_item(bcpe_pkg::OP_EVAL, 3'd2, '0, '0, '0, 17'd40000);
        drain();

        write_point_count(4'd0);
        queue_item(bcpe_pkg::OP_EVAL, 3'd3, '0, '0, '0, 17'd20000);
        drain();

        for (int ph = 0; ph < PHASES; ph++) begin
            // last phase runs with no idling on either side
            src_odds = (ph == PHASES - 1) ? 0 : 3 * $urandom_range(0, 3);
            snk_odds = (ph == PHASES - 1) ? 0 : 3 * $urandom_range(0, 3);
            if ($urandom_range(0, 3) == 0)
                cfg = 4'($urandom_range(0, 15));
            else
                cfg = 4'($urandom_range(1, MAX_PTS));
            write_point_count(cfg);
            repeat (PHASE_ITEMS) begin
                if ($urandom_range(0, 9) < 4)
                    queue_item(bcpe_pkg::OP_LOAD, 3'($urandom_range(0, 7)), pick_coord(),
                               pick_coord(), pick_coord(), pick_u());
                else
                    queue_item(bcpe_pkg::OP_EVAL, 3'($urandom_range(0, 7)), pick_coord(),
                               pick_coord(), pick_coord(), pick_u());
            end
            drain();
        end

        if (mismatches == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
